/* rtl/rsm_pkg.sv */
// ----------------------------------------------------------------------------
// rsm_pkg: shared types, constants and tables for the row softmax block
// Payload structs, row sizing and the exponent lookup tables.
// ----------------------------------------------------------------------------
package rsm_pkg;

  localparam int unsigned RowMax   = 64;
  localparam int unsigned IdxW     = (RowMax > 1) ? $clog2(RowMax) : 1;
  localparam int unsigned CntW     = $clog2(RowMax + 1);
  localparam int unsigned ExpW     = 17;
  localparam int unsigned SumW     = 23;
  localparam int unsigned ZeroFrom = 12;

  typedef struct packed {
    logic signed [15:0] score;
    logic               end_of_row;
  } rsm_in_t;

  typedef struct packed {
    logic [15:0] probability;
    logic [5:0]  element_index;
    logic        last;
    logic        truncated;
  } rsm_out_t;

  // fractional exponent table, indexed by the low byte of g*(max-x)
  typedef logic [255:0][30:0] frac_tab_t;

  // shift-subtract quotient of a by a small d (1..16), table build only
  function automatic logic [31:0] cdiv(input logic [31:0] a, input logic [4:0] d);
    logic [31:0] quo;
    logic [5:0]  rem;
    quo = '0;
    rem = '0;
    for (int b = 31; b >= 0; b--) begin
      rem = {rem[4:0], a[b]};
      if (rem >= {1'b0, d}) begin
        rem    = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-r/256) in Q0.30, 16-term alternating Taylor sum, clamped to 0..2^30
  function automatic logic [30:0] exp_frac(input logic [8:0] r);
    logic [63:0] term;
    logic signed [63:0] acc;
    logic [31:0] num;
    term = 64'd1 << 30;
    acc  = 64'sd1 <<< 30;
    for (int n = 1; n <= 16; n++) begin
      // floor(term*r/(256*n)) = floor(floor(term*r/256)/n)
      num  = 32'((term * 64'(r)) >> 8);
      term = 64'(cdiv(num, 5'(n)));
      if (n[0]) acc = acc - $signed(term);
      else      acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
    return acc[30:0];
  endfunction

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t tab;
    for (int r = 0; r < 256; r++) tab[r] = exp_frac(9'(r));
    return tab;
  endfunction

  localparam frac_tab_t   FracTab = build_frac_tab();
  // exp(-1) in Q0.30
  localparam logic [30:0] ExpOne  = exp_frac(9'd256);

endpackage

/* rtl/rsm_div.sv */
// ----------------------------------------------------------------------------
// rsm_div: restoring divider
// Computes min(floor(num*65536/den), 65535), or 0 when den is 0, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsm_div import rsm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ExpW-1:0] num_i,
  input  logic [SumW-1:0] den_i,
  output logic            done_o,
  output logic [15:0]     quot_o
);

  localparam int unsigned QW = ExpW + 16;

  logic [QW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [SumW-1:0] den_q;
  logic [5:0]      step_q, step_d;
  logic            busy_q, busy_d;
  logic [QW:0]     trial;

  // one shift-subtract step per cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    trial  = '0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = {num_i, 16'd0};
      step_d = 6'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[QW-1]} - {(QW+1-SumW)'(0), den_q};
      if (!trial[QW]) rem_d = trial[QW-1:0];
      else            rem_d = {rem_q[QW-2:0], quo_q[QW-1]};
      quo_d  = {quo_q[QW-2:0], !trial[QW]};
      step_d = step_q - 6'd1;
      if (step_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = busy_q && (step_q == 6'd1);
  // the final step's quotient bit is in quo_d
  assign quot_o = (den_q == '0) ? 16'd0 :
                  (quo_d[QW-1:16] != '0) ? 16'hFFFF : quo_d[15:0];

endmodule

/* rtl/row_softmax.sv */
// ----------------------------------------------------------------------------
// row_softmax: max-subtracted softmax over one row of Q8.8 scores
// Two memories hold scores and exponents; a sequencer runs the row passes.
// ----------------------------------------------------------------------------
// Scores are taken one per cycle while a row loads. On the end-of-row transfer
// the block runs an exponent pass and then an output pass. The exponent pass
// takes each element through a memory read, a table lookup of the fractional
// part of g*(max-x), q multiplies by exp(-1) where q (0 to 11) is the integer
// part, then a write back with a running sum; elements whose integer part
// reaches 12 skip the multiplies. The output pass takes each element through a
// memory read, a divider start and the steps of a bit-serial divider, and a
// result can wait on out_ready_i; the divider sets the output rate. No input is
// taken while a row's results are in progress. Up to 64 elements are stored;
// extra ones are dropped and flagged on every result of the row.
module row_softmax import rsm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rsm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rsm_out_t out_data_o
);

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,
    S_ERD  = 7'b0000010,
    S_ESET = 7'b0000100,
    S_EPOW = 7'b0001000,
    S_EWR  = 7'b0010000,
    S_DRD  = 7'b0100000,
    S_DIV  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]            gain_q;
  logic [CntW-1:0]       cnt_q;
  logic signed [15:0]    max_q;
  logic [SumW-1:0]       sum_q;
  logic                  ovf_q;
  logic [IdxW-1:0]       k_q;
  logic                  out_pend_q;
  rsm_out_t              out_q;
  logic [30:0]           v_q;
  logic [3:0]            pw_q;
  logic                  ez_q;
  logic                  drd_vld_q;

  logic [15:0]           score_mem [RowMax];
  logic [ExpW-1:0]       exp_mem   [RowMax];
  logic [15:0]           score_rd_q;
  logic [ExpW-1:0]       exp_rd_q;

  logic                  in_fire, store_en, row_end, k_last;
  logic [2:0]            gain_eff;
  logic [16:0]           diff;
  logic [19:0]           dscaled;
  logic                  zero_exp;
  logic [61:0]           prod;
  logic [31:0]           v_rnd;
  logic [ExpW-1:0]       e_val;
  logic                  div_done;
  logic [15:0]           div_q;

  assign in_ready_o = (state_q == S_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign store_en   = in_fire && (cnt_q != CntW'(RowMax));
  assign row_end    = in_fire && in_data_i.end_of_row;
  assign k_last     = ({1'b0, k_q} == cnt_q - CntW'(1));

  // gain clamp: 0 acts as 1, above 4 acts as 4
  always_comb begin
    gain_eff = gain_q;
    if (gain_q == 3'd0) gain_eff = 3'd1;
    if (gain_q > 3'd4)  gain_eff = 3'd4;
  end

  // scaled distance from the maximum; zero once the integer part hits the cutoff
  assign diff     = 17'($signed(max_q) - $signed(score_rd_q));
  assign dscaled  = 20'(diff) * 20'(gain_eff);
  assign zero_exp = (dscaled[19:8] >= 12'(ZeroFrom));

  // one exp(-1) step per cycle, rounded back to Q0.30
  assign prod  = {31'd0, v_q} * {31'd0, ExpOne} + (62'd1 << 29);
  // Q0.30 to Q1.16 with rounding
  assign v_rnd = {1'b0, v_q} + 32'd8192;
  assign e_val = ez_q ? '0 : v_rnd[30:14];

  // memories, registered read
  always_ff @(posedge clk_i) begin
    if (store_en) score_mem[cnt_q[IdxW-1:0]] <= in_data_i.score;
    score_rd_q <= score_mem[k_q];
    if (state_q == S_EWR) exp_mem[k_q] <= e_val;
    exp_rd_q <= exp_mem[k_q];
  end

  rsm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DRD && drd_vld_q && !out_pend_q),
    .num_i   (exp_rd_q),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: if (row_end) state_d = S_ERD;
      S_ERD:  state_d = S_ESET;
      S_ESET: state_d = S_EPOW;
      S_EPOW: if (pw_q == 4'd0) state_d = S_EWR;
      S_EWR:  state_d = k_last ? S_DRD : S_ERD;
      S_DRD:  if (!out_pend_q && drd_vld_q) state_d = S_DIV;
      S_DIV:  if (div_done) state_d = k_last ? S_LOAD : S_DRD;
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      gain_q     <= 3'd1;
      cnt_q      <= '0;
      max_q      <= '0;
      sum_q      <= '0;
      ovf_q      <= 1'b0;
      k_q        <= '0;
      out_pend_q <= 1'b0;
      v_q        <= '0;
      pw_q       <= '0;
      ez_q       <= 1'b0;
      drd_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // exponent read data is valid in S_DRD once drd_vld_q is set
      drd_vld_q <= (state_q == S_DRD);
      if (cfg_we_i) gain_q <= cfg_wdata_i;
      if (out_valid_o && out_ready_i) out_pend_q <= 1'b0;
      case (state_q)
        S_LOAD: begin
          if (store_en) begin
            if (cnt_q == '0 || $signed(in_data_i.score) > max_q) max_q <= in_data_i.score;
            cnt_q <= cnt_q + CntW'(1);
          end else if (in_fire) begin
            ovf_q <= 1'b1;
          end
          k_q   <= '0;
          sum_q <= '0;
        end
        S_ESET: begin
          v_q  <= FracTab[dscaled[7:0]];
          pw_q <= zero_exp ? 4'd0 : dscaled[11:8];
          ez_q <= zero_exp;
        end
        S_EPOW: begin
          if (pw_q != 4'd0) begin
            v_q  <= prod[60:30];
            pw_q <= pw_q - 4'd1;
          end
        end
        S_EWR: begin
          sum_q <= sum_q + SumW'(e_val);
          k_q   <= k_last ? '0 : k_q + IdxW'(1);
        end
        S_DIV: begin
          if (div_done) begin
            out_pend_q <= 1'b1;
            if (k_last) begin
              cnt_q <= '0;
              max_q <= '0;
              ovf_q <= 1'b0;
            end else begin
              k_q <= k_q + IdxW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV && div_done) begin
      out_q.probability   <= div_q;
      out_q.element_index <= 6'(k_q);
      out_q.last          <= k_last;
      out_q.truncated     <= ovf_q;
    end
  end

  assign out_valid_o = out_pend_q;
  assign out_data_o  = out_q;

  // no new row is taken while results are being produced
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> !in_ready_o) else $error("input taken mid row");
  // a pending result is not overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(out_data_o))
    else $error("result lost");
  // count never exceeds row capacity
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(RowMax)) else $error("count overflow");

endmodule

/* sim/tb_row_softmax.sv */
// ----------------------------------------------------------------------------
// tb_row_softmax: self-checking testbench for the row softmax block
// Rows of Q8.8 scores go in over a valid/ready channel. A predictor in the
// bench computes the exponents, the row sum and the normalized Q0.16 results.
// Every output transfer is checked against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_row_softmax import rsm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 60;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we_i = 1'b0;
  logic [2:0] cfg_wdata_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  rsm_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  rsm_out_t out_data_o;

  row_softmax i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: gain register and the row being collected
  logic [2:0]         gain_reg = 3'd1;
  logic signed [15:0] row_scores [RowMax];
  int unsigned        row_count = 0;
  logic signed [15:0] row_peak = '0;
  bit                 row_dropped = 1'b0;
  rsm_out_t           expected_probs [$];

  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned rows_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // exp(-r/256) as Q0.30, truncated alternating series
  function automatic longint unsigned exp_fraction(int unsigned r);
    longint unsigned term;
    longint          acc;
    term = 64'd1 << 30;
    acc  = longint'(64'd1 << 30);
    for (int n = 1; n <= 16; n++) begin
      term = (term * r) / (64'd256 * n);
      if (n % 2 == 1) acc -= longint'(term);
      else            acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(64'd1 << 30)) acc = longint'(64'd1 << 30);
    return longint'(acc);
  endfunction

  // exp(-d/256) rounded to Q1.16, zero once the integer part reaches ZeroFrom
  function automatic int unsigned exp_weight(int unsigned d);
    longint unsigned v;
    longint unsigned e_one;
    if ((d >> 8) >= ZeroFrom) return 0;
    v     = exp_fraction(d & 255);
    e_one = exp_fraction(256);
    for (int i = 0; i < int'(d >> 8); i++) v = (v * e_one + (64'd1 << 29)) >> 30;
    return int'((v + 64'd8192) >> 14);
  endfunction

  // Accepted input: collect the score, and on end of row queue the results
  task automatic predict_row_item(rsm_in_t item);
    int unsigned     g;
    int unsigned     weights [RowMax];
    int unsigned     sum;
    longint unsigned p;
    rsm_out_t        res;
    if (row_count < RowMax) begin
      if (row_count == 0 || item.score > row_peak) row_peak = item.score;
      row_scores[row_count] = item.score;
      row_count++;
    end else begin
      row_dropped = 1'b1;
    end
    if (!item.end_of_row) return;
    g = 32'(gain_reg);
    if (g < 1) g = 1;
    if (g > 4) g = 4;
    sum = 0;
    for (int k = 0; k < row_count; k++) begin
      weights[k] = exp_weight(g * int'(int'(row_peak) - int'(row_scores[k])))
                   & 32'h1FFFF;
      sum = (sum + weights[k]) & 32'h7FFFFF;
    end
    for (int k = 0; k < row_count; k++) begin
      p = (sum != 0) ? ((64'(weights[k]) << 16) / sum) : 0;
      if (p > 65535) p = 65535;
      res.probability   = p[15:0];
      res.element_index = k[5:0];
      res.last          = (k + 1 == row_count);
      res.truncated     = row_dropped;
      expected_probs.push_back(res);
    end
    row_count   = 0;
    row_peak    = '0;
    row_dropped = 1'b0;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("row_softmax: result %0d %s got %0d want %0d", checked, what, got, want);
    errors++;
  endtask

  // Receiver stalls, changed on the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // Check every output transfer against the oldest expectation
  always @(posedge clk_i) begin
    rsm_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_probs.size() == 0) begin
        report_mismatch("unexpected element_index", out_data_o.element_index, 0);
      end else begin
        want = expected_probs.pop_front();
        if (out_data_o.probability !== want.probability)
          report_mismatch("probability", out_data_o.probability, want.probability);
        if (out_data_o.element_index !== want.element_index)
          report_mismatch("element_index", out_data_o.element_index, want.element_index);
        if (out_data_o.last !== want.last)
          report_mismatch("last", out_data_o.last, want.last);
        if (out_data_o.truncated !== want.truncated)
          report_mismatch("truncated", out_data_o.truncated, want.truncated);
      end
      checked++;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("row_softmax: timeout after %0d cycles", cycles);
      $display("row_softmax: mismatch");
      $finish;
    end
  end

  // Send one row element; returns at a falling edge with valid still high
  task automatic send_score(logic signed [15:0] score, bit eor);
    rsm_in_t item;
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    item.score      = score;
    item.end_of_row = eor;
    in_data_i  = item;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_row_item(item);
    items_sent++;
    if (eor) rows_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_row(logic signed [15:0] scores [$]);
    foreach (scores[k]) send_score(scores[k], k == scores.size() - 1);
  endtask

  // Wait for all results, then let the block settle
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (expected_probs.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_gain(logic [2:0] g);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = g;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    gain_reg = g;
  endtask

  function automatic logic signed [15:0] clamp_score(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // Short rows at the field extremes, at the default gain and at gains 4, 0 and 7
  task automatic test_extremes();
    send_row('{16'sd0});
    send_row('{-16'sd32768});
    send_row('{16'sd32767, -16'sd32768});
    send_row('{-16'sd32768, -16'sd32768, -16'sd32768});
    send_row('{16'sd0, 16'sd256, 16'sd512, -16'sd256, 16'sd3072});
    write_gain(3'd4);
    send_row('{16'sd0, -16'sd128, -16'sd768, -16'sd1});
    write_gain(3'd0);
    send_row('{16'sd100, 16'sd101, 16'sd99});
    write_gain(3'd7);
    send_row('{16'sd32767, 16'sd32000, 16'sd32767});
  endtask

  // A full row, and one row past the limit whose end mark arrives on a dropped score
  task automatic test_long_rows();
    logic signed [15:0] scores [$];
    write_gain(3'd1);
    for (int k = 0; k < RowMax; k++) scores.push_back(clamp_score(k * 40 - 1200));
    send_row(scores);
    scores = {};
    for (int k = 0; k < RowMax + 2; k++) scores.push_back(clamp_score(k * 17));
    send_row(scores);
  endtask

  // Random rows, mostly short with close scores, a few full or overlong
  task automatic random_rows(int unsigned n_items);
    logic signed [15:0] scores [$];
    int unsigned len;
    int unsigned pick;
    int base;
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99, 0);
      if (pick < 4)      len = RowMax + $urandom_range(4, 1);
      else if (pick < 8) len = RowMax;
      else               len = $urandom_range(12, 1);
      base = int'($signed(16'($urandom())));
      scores = {};
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(3, 0) == 0)
          scores.push_back($signed(16'($urandom())));
        else
          scores.push_back(clamp_score(base + int'($urandom_range(3072, 0)) - 1536));
      end
      send_row(scores);
    end
  endtask

  task automatic test_random_phase(int unsigned idle, int unsigned stall,
                                   logic [2:0] g_a, logic [2:0] g_b);
    wait_idle();
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    write_gain(g_a);
    random_rows(28);
    write_gain(g_b);
    random_rows(28);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_long_rows();
    test_random_phase(0, 0, 3'd1, 3'd4);
    test_random_phase(72, 0, 3'd3, 3'd2);
    test_random_phase(0, 72, 3'd0, 3'd5);
    test_random_phase(32, 32, 3'd6, 3'd7);

    wait_idle();
    $display("row_softmax: %0d scores in %0d rows, %0d results checked", items_sent,
             rows_sent, checked);
    $display("row_softmax: gains 0..7, full and overlong rows, four idle/stall mixes");
    if (errors == 0) begin
      $display("row_softmax: match");
    end else begin
      $display("row_softmax: mismatch");
    end
    $finish;
  end

endmodule
